### src/sdtr_pkg.sv
// ----------------------------------------------------------------------------
// sdtr_pkg: shared types and constants for the deadband threshold reporter
// Register map indexes, status codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package sdtr_pkg;

  // Field widths
  localparam int SampleW = 32;
  localparam int HystW   = 20;
  localparam int ThrW    = 25;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  // Register indexes (word address paddr[4:2])
  localparam logic [2:0] REG_HYSTERESIS   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_INVERT_ALARM = 3'd2;
  localparam logic [2:0] REG_ERROR_CODE   = 3'd3;
  localparam logic [2:0] REG_ERROR_CHECK  = 3'd4;

  // Register reset values
  localparam logic [HystW-1:0]          HYST_RESET      = HystW'(100);
  localparam logic signed [ThrW-1:0]    THR_RESET       = ThrW'(4000);
  localparam logic                      INVERT_RESET    = 1'b0;
  localparam logic signed [SampleW-1:0] ERR_CODE_RESET  = '0;
  localparam logic                      ERR_CHECK_RESET = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_VALUE_ERR = 2'd1,
    STATUS_READ_ERR  = 2'd2
  } status_t;

endpackage

### src/sensor_deadband_threshold_reporter_top.sv
// ----------------------------------------------------------------------------
// sensor_deadband_threshold_reporter_top: deadband report and alarm block
// Checks one polled sensor sample per item, flags bad reads and error values,
// issues value reports past a deadband and on/off alarm commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with sample and read_ok. An item is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid/out_stall with status, report_now, report_value,
//   alarm_event and alarm_on; exactly one result per input item, in order.
//   Configuration: APB-style port, registers at byte addresses 0,4,8,12,16
//   (hysteresis, threshold_level, invert_alarm, error_code,
//   error_check_enable). pready is tied high; write only while idle.
//   Path: a taken item is loaded into the input register, then into the
//   result register once that is free or its result is being taken.
//   Throughput: one item per cycle unless the output stalls, set by the single
//   compare stage between the two registers, which also updates channel state.
//   Reset (rst, synchronous): both registers empty, registers back to their
//   defaults, channel uninitialized and not triggered.
//   Stall: a stalled result holds; one more item waits in the input register,
//   after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module sensor_deadband_threshold_reporter_top
  import sdtr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SampleW-1:0] sample,
  input  logic                      read_ok,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic                      report_now,
  output logic signed [SampleW-1:0] report_value,
  output logic                      alarm_event,
  output logic                      alarm_on,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  // Configuration registers
  logic [HystW-1:0]          hysteresis;
  logic signed [ThrW-1:0]    threshold_level;
  logic                      invert_alarm;
  logic signed [SampleW-1:0] error_code;
  logic                      error_check_enable;

  // Channel state
  logic signed [SampleW-1:0] last_reported;
  logic                      triggered;
  logic                      initialized;

  // Input register
  logic                      in_full;
  logic signed [SampleW-1:0] in_sample;
  logic                      in_ok;

  // Stage logic
  logic                      advance;
  logic                      cfg_write;
  logic [2:0]                reg_index;
  status_t                   status_next;
  logic                      report_next;
  logic signed [SampleW-1:0] report_value_next;
  logic                      event_next;
  logic                      level_next;
  logic                      triggered_next;
  logic signed [SampleW:0]   diff;
  logic [SampleW:0]          diff_mag;
  logic signed [SampleW+1:0] v_wide;
  logic signed [SampleW+1:0] h_wide;
  logic signed [SampleW+1:0] thr_wide;

  assign pready    = 1'b1;
  assign reg_index = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis         <= HYST_RESET;
      threshold_level    <= THR_RESET;
      invert_alarm       <= INVERT_RESET;
      error_code         <= ERR_CODE_RESET;
      error_check_enable <= ERR_CHECK_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_HYSTERESIS:   hysteresis         <= pwdata[HystW-1:0];
        REG_THRESHOLD:    threshold_level    <= pwdata[ThrW-1:0];
        REG_INVERT_ALARM: invert_alarm       <= pwdata[0];
        REG_ERROR_CODE:   error_code         <= pwdata;
        REG_ERROR_CHECK:  error_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_index)
      REG_HYSTERESIS:   prdata = {{(DataW-HystW){1'b0}}, hysteresis};
      REG_THRESHOLD:    prdata = {{(DataW-ThrW){threshold_level[ThrW-1]}}, threshold_level};
      REG_INVERT_ALARM: prdata = {{(DataW-1){1'b0}}, invert_alarm};
      REG_ERROR_CODE:   prdata = error_code;
      REG_ERROR_CHECK:  prdata = {{(DataW-1){1'b0}}, error_check_enable};
      default:          prdata = '0;
    endcase
  end

  // Move an item from the input register when the result register is free or being taken
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_sample <= sample;
      in_ok     <= read_ok;
    end
  end

  // Deadband distance and widened alarm operands
  assign diff     = {in_sample[SampleW-1], in_sample}
                  - {last_reported[SampleW-1], last_reported};
  assign diff_mag = diff[SampleW] ? (SampleW+1)'(0) - diff : diff;
  assign v_wide   = {{2{in_sample[SampleW-1]}}, in_sample};
  assign h_wide   = {{(SampleW+2-HystW){1'b0}}, hysteresis};
  assign thr_wide = {{(SampleW+2-ThrW){threshold_level[ThrW-1]}}, threshold_level};

  // Classify the sample, decide the report and the alarm change
  always_comb begin
    status_next       = STATUS_OK;
    report_next       = 1'b0;
    report_value_next = '0;
    event_next        = 1'b0;
    level_next        = 1'b0;
    triggered_next    = triggered;
    if (!in_ok) begin
      status_next = STATUS_READ_ERR;
    end else if (error_check_enable && (in_sample == error_code)) begin
      status_next = STATUS_VALUE_ERR;
    end else begin
      if (!initialized
          || ((hysteresis != '0) && (diff_mag > {{(SampleW+1-HystW){1'b0}}, hysteresis}))) begin
        report_next       = 1'b1;
        report_value_next = in_sample;
      end
      if (triggered) begin
        if ((v_wide + h_wide) < thr_wide) begin
          triggered_next = 1'b0;
          event_next     = 1'b1;
          level_next     = invert_alarm;
        end
      end else begin
        if ((v_wide - h_wide) > thr_wide) begin
          triggered_next = 1'b1;
          event_next     = 1'b1;
          level_next     = !invert_alarm;
        end
      end
    end
  end

  // Update channel state as the item passes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_reported <= '0;
      triggered     <= 1'b0;
      initialized   <= 1'b0;
    end else if (advance) begin
      triggered <= triggered_next;
      if (report_next) begin
        last_reported <= in_sample;
        initialized   <= 1'b1;
      end
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= status_next;
      report_now   <= report_next;
      report_value <= report_value_next;
      alarm_event  <= event_next;
      alarm_on     <= level_next;
    end
  end

`ifndef SYNTHESIS
  // A bad sample carries no report and no alarm command
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> !report_now && !alarm_event)
    else $error("bad sample produced a report or alarm");

  // No command level without an alarm change, no report value without a report
  a_level_needs_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alarm_event |-> !alarm_on && (report_now || report_value == '0))
    else $error("alarm level or report value set without its flag");

  // A flip of the trigger flag shows as an alarm event in the next result
  a_trigger_event: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (triggered != $past(triggered)) |-> out_valid && alarm_event)
    else $error("trigger flag changed without an alarm event");

  // The channel becomes initialized only through a report
  a_init_report: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(initialized) |-> out_valid && report_now)
    else $error("channel initialized without a report");

  // Command level follows the new trigger flag and the invert setting
  a_level_match: assert property (@(posedge clk) disable iff (rst)
    advance && event_next |=> alarm_on == (triggered ^ invert_alarm))
    else $error("alarm level does not match trigger flag");
`endif

endmodule

### tb/sv/sdtr_report_checker.sv
// ----------------------------------------------------------------------------
// sdtr_report_checker: result predictor and scoreboard for the reporter block
// Watches the input, output and configuration ports, keeps its own copy of
// the registers and channel state, predicts one report per accepted item and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sdtr_report_checker
  import sdtr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [SampleW-1:0] sample,
  input  logic                      read_ok,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                status,
  input  logic                      report_now,
  input  logic signed [SampleW-1:0] report_value,
  input  logic                      alarm_event,
  input  logic                      alarm_on,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [DataW-1:0]          pwdata,
  input  logic                      pready,
  output int                        fail_count,
  output int                        reports_due
);

  typedef struct {
    status_t                   status;
    logic                      report_now;
    logic signed [SampleW-1:0] report_value;
    logic                      alarm_event;
    logic                      alarm_on;
  } report_t;

  // Register shadow copies
  logic [HystW-1:0]          hyst_q;
  logic signed [ThrW-1:0]    thr_q;
  logic                      invert_q;
  logic signed [SampleW-1:0] err_code_q;
  logic                      err_check_q;

  // Channel state
  logic signed [SampleW-1:0] last_value;
  logic                      tripped;
  logic                      seen_first;

  report_t expected_reports[$];
  int      errors = 0;
  report_t want;

  // Work out the report for one sample and advance the channel state
  function automatic report_t predict_report(input logic signed [SampleW-1:0] value,
                                             input logic ok);
    report_t r;
    longint  v;
    longint  h;
    longint  t;
    longint  gap;
    r = '{STATUS_OK, 1'b0, '0, 1'b0, 1'b0};
    v = longint'(value);
    h = longint'(hyst_q);
    t = longint'(thr_q);
    if (!ok) begin
      r.status = STATUS_READ_ERR;
    end else if (err_check_q && value == err_code_q) begin
      r.status = STATUS_VALUE_ERR;
    end else begin
      gap = v - longint'(last_value);
      if (gap < 0) gap = -gap;
      // report on first good sample or when outside the deadband
      if (!seen_first || (h != 0 && gap > h)) begin
        last_value     = value;
        seen_first     = 1'b1;
        r.report_now   = 1'b1;
        r.report_value = value;
      end
      // flip the trigger flag across the hysteresis band
      if (tripped) begin
        if (v + h < t) begin
          tripped       = 1'b0;
          r.alarm_event = 1'b1;
          r.alarm_on    = invert_q;
        end
      end else if (v - h > t) begin
        tripped       = 1'b1;
        r.alarm_event = 1'b1;
        r.alarm_on    = !invert_q;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [SampleW:0] exp_v,
                                      input logic signed [SampleW:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      hyst_q      = HYST_RESET;
      thr_q       = THR_RESET;
      invert_q    = INVERT_RESET;
      err_code_q  = ERR_CODE_RESET;
      err_check_q = ERR_CHECK_RESET;
      last_value  = '0;
      tripped     = 1'b0;
      seen_first  = 1'b0;
      expected_reports.delete();
      reports_due <= 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_HYSTERESIS:   hyst_q      = pwdata[HystW-1:0];
          REG_THRESHOLD:    thr_q       = pwdata[ThrW-1:0];
          REG_INVERT_ALARM: invert_q    = pwdata[0];
          REG_ERROR_CODE:   err_code_q  = pwdata[SampleW-1:0];
          REG_ERROR_CHECK:  err_check_q = pwdata[0];
          default: ;
        endcase
      end
      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no item pending: status %0d, report_value %0d",
                 status, report_value);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", (SampleW+1)'(want.status), (SampleW+1)'(status));
          check_field("report_now", (SampleW+1)'(want.report_now),
                      (SampleW+1)'(report_now));
          check_field("report_value", (SampleW+1)'(want.report_value),
                      (SampleW+1)'(report_value));
          check_field("alarm_event", (SampleW+1)'(want.alarm_event),
                      (SampleW+1)'(alarm_event));
          check_field("alarm_on", (SampleW+1)'(want.alarm_on), (SampleW+1)'(alarm_on));
        end
      end
      // predict for an accepted item
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_report(sample, read_ok));
      end
      reports_due <= expected_reports.size();
    end
    fail_count <= errors;
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the deadband threshold reporter
// Drives directed and random sensor samples through the input channel under
// several register settings and idle patterns, stalls the result channel,
// and gives the verdict from the checker's failure and pending report counts.
// ----------------------------------------------------------------------------
module tb_top;
  import sdtr_pkg::*;

  localparam int CycleLimit = 200000;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SampleW-1:0] sample;
  logic                      read_ok;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                status;
  logic                      report_now;
  logic signed [SampleW-1:0] report_value;
  logic                      alarm_event;
  logic                      alarm_on;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [AddrW-1:0]          paddr;
  logic [DataW-1:0]          pwdata;
  logic [DataW-1:0]          prdata;
  logic                      pready;

  int fail_count;
  int reports_due;
  int cycle_count = 0;

  // Idle control: idle_pct is read only by the stimulus, stall_pct by the receiver
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_request = 0;
  logic hold_toggle = 1'b0;

  // Stimulus shaping copies of the current settings
  longint                    cur_hyst;
  longint                    cur_thr;
  logic signed [SampleW-1:0] cur_err;
  longint                    walk;

  sensor_deadband_threshold_reporter_top DUT (.*);

  sdtr_report_checker report_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sensor_deadband_threshold_reporter_top verification failed");
      $finish;
    end
  end

  // Result receiver: random stall, or a long hold-off on request
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = hold_request;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one item, with a random gap ahead of it, and wait until it is taken
  task automatic send_item(input logic signed [SampleW-1:0] value, input logic ok);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    sample   <= value;
    read_ok  <= ok;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted report has arrived
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 49; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 49; end
      default: begin idle_pct = 35; stall_pct <= 35; end
    endcase
  endtask

  // Random samples aimed at the threshold edges, the deadband and the error code
  task automatic run_random(input int count);
    int     pick;
    longint val;
    longint span;
    logic   ok;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      ok   = 1'b1;
      if (pick < 8) begin
        ok  = 1'b0;
        val = $signed($urandom);
      end else if (pick < 15) begin
        val = cur_err;
      end else if (pick < 27) begin
        val = $signed($urandom);
      end else if (pick < 47) begin
        val = cur_thr + ($urandom_range(1) ? cur_hyst : -cur_hyst)
              + longint'($urandom_range(2)) - 1;
      end else begin
        if ($urandom_range(19) == 0) walk = cur_thr;
        span = 2 * cur_hyst + 3;
        walk = walk + longint'($urandom_range(2 * span)) - span;
        if (walk > 64'sd2147483647) walk = 64'sd2147483647;
        if (walk < -64'sd2147483648) walk = -64'sd2147483648;
        val = walk;
      end
      if (pick >= 8 && pick < 15 && $urandom_range(9) == 0) ok = 1'b0;
      send_item(val[SampleW-1:0], ok);
    end
  endtask

  // Write every register, pick the idle pattern and run a batch of samples
  task automatic run_phase(input logic [DataW-1:0] hyst_bits, input logic [DataW-1:0] thr_bits,
                           input logic [DataW-1:0] inv_bits, input logic [DataW-1:0] err_bits,
                           input logic [DataW-1:0] chk_bits, input int count, input int mode,
                           input int hold);
    settle();
    write_reg(REG_HYSTERESIS, hyst_bits);
    write_reg(REG_THRESHOLD, thr_bits);
    write_reg(REG_INVERT_ALARM, inv_bits);
    write_reg(REG_ERROR_CODE, err_bits);
    write_reg(REG_ERROR_CHECK, chk_bits);
    cur_hyst = hyst_bits[HystW-1:0];
    cur_thr  = $signed(thr_bits[ThrW-1:0]);
    cur_err  = err_bits[SampleW-1:0];
    walk     = cur_thr;
    set_idling(mode);
    if (hold > 0) begin
      hold_request <= hold;
      hold_toggle  <= ~hold_toggle;
    end
    run_random(count);
  endtask

  initial begin
    logic [DataW-1:0] r_hyst;
    logic [DataW-1:0] r_thr;
    logic [DataW-1:0] r_err;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    sample   <= '0;
    read_ok  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings: hysteresis 100, threshold 4000, code 0
    set_idling(0);
    send_item(32'sh7FFFFFFF, 1'b0);  // read failure while uninitialized
    send_item(32'sd0, 1'b1);          // error value
    send_item(32'sd0, 1'b0);          // read failure wins over error value
    send_item(-32'sh80000000, 1'b1);  // first good sample reports
    send_item(32'sh7FFFFFFF, 1'b1);   // far jump, alarm on
    send_item(32'sh7FFFFFFF, 1'b1);   // no change
    send_item(32'sd4100, 1'b1);       // report, v + h not below threshold
    send_item(32'sd3899, 1'b1);       // alarm off
    send_item(32'sd4100, 1'b1);       // v - h equals threshold, no alarm
    send_item(32'sd4101, 1'b1);       // alarm on, inside deadband
    send_item(32'sd4200, 1'b1);       // difference equals deadband, no report
    send_item(32'sd4201, 1'b1);       // difference just past deadband
    send_item(32'sd3900, 1'b1);       // v + h equals threshold, flag holds
    send_item(32'sd3899, 1'b1);       // alarm off
    send_item(32'sd4000, 1'b0);
    send_item(-32'sd1, 1'b1);
    send_item(32'sd1, 1'b1);
    send_item(32'sh55555555, 1'b1);
    send_item(32'shAAAAAAAA, 1'b1);
    send_item(32'sd0, 1'b1);

    // Setting extremes, the first with a long receiver hold-off
    run_phase(32'd0, -32'sd4000, 32'd1, 32'h80000000, 32'd1, 90, 0, 150);
    run_phase(32'd1000000, 32'd10000000, 32'd0, 32'h7FFFFFFF, 32'd1, 90, 1, 0);
    run_phase(32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 90, 2, 0);
    // Out-of-range bit patterns: upper bits are dropped
    run_phase(32'hFFFFFFFF, 32'hABFFFFFF, 32'hFFFFFFFE, 32'h00001234, 32'h3, 80, 3, 0);

    // Random settings
    for (int p = 0; p < 4; p++) begin
      r_hyst = ($urandom_range(3) == 0) ? $urandom_range(1000000) : $urandom_range(300);
      r_thr  = $urandom_range(10004000) - 4000;
      r_err  = $urandom_range(1) ? $urandom : $signed(r_thr[ThrW-1:0]) + $urandom_range(50);
      run_phase(r_hyst, r_thr, $urandom_range(1), r_err, $urandom_range(3) != 0, 85, p, 0);
    end

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && reports_due == 0) begin
      $display("sensor_deadband_threshold_reporter_top verification clean");
    end else begin
      $display("sensor_deadband_threshold_reporter_top verification failed");
    end
    $finish;
  end

endmodule
